### rtl/core/ps2_mouse_device_defines.svh
// ----------------------------------------------------------------------------
// PS/2 mouse device assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_DEVICE_DEFINES_SVH
`define PS2_MOUSE_DEVICE_DEFINES_SVH

// condition holds at every edge
`define PMD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent in the same cycle
`define PMD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the next cycle
`define PMD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/pmd_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 mouse device package
// Shared widths, command codes, queue entry type and arithmetic helpers.
// ----------------------------------------------------------------------------
package pmd_pkg;

    localparam int ACC_BITS    = 12;
    localparam int DELTA_LIMIT = 255;
    localparam int DELTA_W     = 11;
    localparam int SUM_W       = ((ACC_BITS > DELTA_W) ? ACC_BITS : DELTA_W) + 1;
    localparam int RY_W        = ACC_BITS + 1;
    localparam int CLAMP_W     = $clog2(DELTA_LIMIT + 1) + 1;
    localparam int ACC_MAX     = (1 << (ACC_BITS - 1)) - 1;
    localparam int ACC_MIN     = -ACC_MAX - 1;
    localparam int MAX_OUT     = 28;
    localparam int CNT_W       = $clog2(MAX_OUT + 1);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef logic signed [ACC_BITS-1:0] acc_t;
    typedef logic signed [DELTA_W-1:0]  delta_t;
    typedef logic signed [RY_W-1:0]     wide_t;
    typedef logic signed [CLAMP_W-1:0]  clamp_t;

    localparam wide_t LIM_P = RY_W'(DELTA_LIMIT);
    localparam wide_t LIM_N = RY_W'(-DELTA_LIMIT);

    // item kinds (op field)
    localparam logic [1:0] KIND_MOTION = 2'd0;
    localparam logic [1:0] KIND_BUTTON = 2'd1;
    localparam logic [1:0] KIND_HOST   = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    // host commands and response bytes
    localparam logic [7:0] CMD_SCALE11   = 8'hE6;
    localparam logic [7:0] CMD_SCALE21   = 8'hE7;
    localparam logic [7:0] CMD_SET_RES   = 8'hE8;
    localparam logic [7:0] CMD_STATUS    = 8'hE9;
    localparam logic [7:0] CMD_STREAM    = 8'hEA;
    localparam logic [7:0] CMD_READ_DATA = 8'hEB;
    localparam logic [7:0] CMD_REMOTE    = 8'hF0;
    localparam logic [7:0] CMD_GET_ID    = 8'hF2;
    localparam logic [7:0] CMD_SET_RATE  = 8'hF3;
    localparam logic [7:0] CMD_ENABLE    = 8'hF4;
    localparam logic [7:0] CMD_DISABLE   = 8'hF5;
    localparam logic [7:0] CMD_DEFAULTS  = 8'hF6;
    localparam logic [7:0] CMD_RESEND    = 8'hFE;
    localparam logic [7:0] CMD_RESET     = 8'hFF;

    localparam logic [7:0] RSP_ACK      = 8'hFA;
    localparam logic [7:0] RSP_RESEND   = 8'hFE;
    localparam logic [7:0] RSP_BAT_OK   = 8'hAA;
    localparam logic [7:0] RSP_ID       = 8'h00;
    localparam logic [7:0] PKT_B0_BASE  = 8'h08;
    localparam logic [1:0] DEF_RES      = 2'd2;
    localparam logic [7:0] DEF_RATE     = 8'd100;

    typedef struct packed {
        logic [1:0] kind;
        delta_t     dx;
        delta_t     dy;
        logic       which_button;
        logic       pressed;
        logic [7:0] host_byte;
    } pmd_item_t;

    function automatic acc_t acc_add(input acc_t a, input delta_t d);
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(d);
        if (s > SUM_W'(ACC_MAX))
            return acc_t'(ACC_MAX);
        else if (s < SUM_W'(ACC_MIN))
            return acc_t'(ACC_MIN);
        else
            return acc_t'(s);
    endfunction

    function automatic clamp_t clamp_delta(input wide_t v);
        if (v > LIM_P)
            return clamp_t'(LIM_P);
        else if (v < LIM_N)
            return clamp_t'(LIM_N);
        else
            return clamp_t'(v);
    endfunction

endpackage

### rtl/core/pmd_front.sv
// ----------------------------------------------------------------------------
// PS/2 mouse device front end
// Accepts input beats, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module pmd_front
    import pmd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic [31:0] s_tdata,   // delta_x[10:0], delta_y[21:11], which_button[22],
                                   // pressed[23], host_byte[31:24]
    input  logic [1:0] s_tuser,    // op[1:0]
    output pmd_item_t q_item,
    output logic      q_valid,
    input  logic      q_pop
);

    pmd_item_t         entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;
    logic              push;
    pmd_item_t         in_item;

    always_comb
    begin
        in_item.kind         = s_tuser;
        in_item.dx           = s_tdata[10:0];
        in_item.dy           = s_tdata[21:11];
        in_item.which_button = s_tdata[22];
        in_item.pressed      = s_tdata[23];
        in_item.host_byte    = s_tdata[31:24];
    end

    assign s_tready = (fill_reg != (QPTR_W+1)'(QDEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (fill_reg != '0);
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (q_pop && q_valid)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (push && !(q_pop && q_valid))
            fill_next = fill_reg + 1'b1;
        else if (!push && q_pop && q_valid)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= in_item;
    end

endmodule

### rtl/core/pmd_back.sv
// ----------------------------------------------------------------------------
// PS/2 mouse device back end
// Holds the device state, runs commands and sends bytes through an output register.
// ----------------------------------------------------------------------------
`include "ps2_mouse_device_defines.svh"

module pmd_back
    import pmd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  pmd_item_t  q_item,
    input  logic       q_valid,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte[7:0]
    output logic       m_tuser,   // from_stream
    output logic       m_tlast    // last
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RESP = 3'd1;
    localparam logic [2:0] ST_PKT0 = 3'd2;
    localparam logic [2:0] ST_PKT1 = 3'd3;
    localparam logic [2:0] ST_PKT2 = 3'd4;

    logic [2:0] state_reg, state_next;

    acc_t       pend_x_reg, pend_x_next;
    acc_t       pend_y_reg, pend_y_next;
    logic       chg_reg, chg_next;
    logic       left_reg, left_next;
    logic       right_reg, right_next;
    logic       rep_reg, rep_next;
    logic       remote_reg, remote_next;
    logic       scale_reg, scale_next;
    logic       await_reg, await_next;
    logic       is_rate_reg, is_rate_next;
    logic [1:0] res_reg, res_next;
    logic [7:0] rate_reg, rate_next;
    logic [7:0] last_sent_reg, last_sent_next;

    logic [7:0]       resp_reg [4];
    logic [7:0]       resp_next [4];
    logic [2:0]       len_reg, len_next;
    logic [1:0]       idx_reg, idx_next;
    logic             pkt_after_reg, pkt_after_next;
    logic             stream_reg, stream_next;
    logic [7:0]       b1_reg, b1_next, b2_reg, b2_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_data_reg, m_data_next;
    logic       m_user_reg, m_user_next;
    logic       m_last_reg, m_last_next;

    logic       fire, emit, emit_last, more;
    logic [7:0] emit_byte;
    logic       emit_user;

    wide_t      rx, ry;
    clamp_t     cx, cy;
    logic [7:0] b0;
    logic [7:0] status;

    assign fire = !m_valid_reg || m_tready;
    assign q_pop = (state_reg == ST_IDLE) && q_valid;

    // another stream packet follows the byte now going out
    assign more = ((pend_x_reg != '0) || (pend_y_reg != '0) || chg_reg)
                  && rep_reg && !remote_reg
                  && (cnt_reg <= CNT_W'(MAX_OUT - 4));

    always_comb
    begin
        rx = RY_W'(pend_x_reg);
        ry = -(RY_W'(pend_y_reg));
        cx = clamp_delta(rx);
        cy = clamp_delta(ry);
        b0 = PKT_B0_BASE;
        b0[0] = left_reg;
        b0[1] = right_reg;
        b0[4] = cx[CLAMP_W-1];
        b0[5] = cy[CLAMP_W-1];
        b0[6] = (rx > LIM_P) || (rx < LIM_N);
        b0[7] = (ry > LIM_P) || (ry < LIM_N);
        status = {1'b0, remote_reg, rep_reg, scale_reg, 2'b00, right_reg, left_reg};
    end

    always_comb
    begin
        state_next     = state_reg;
        pend_x_next    = pend_x_reg;
        pend_y_next    = pend_y_reg;
        chg_next       = chg_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        rep_next       = rep_reg;
        remote_next    = remote_reg;
        scale_next     = scale_reg;
        await_next     = await_reg;
        is_rate_next   = is_rate_reg;
        res_next       = res_reg;
        rate_next      = rate_reg;
        resp_next      = resp_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        pkt_after_next = pkt_after_reg;
        stream_next    = stream_reg;
        b1_next        = b1_reg;
        b2_next        = b2_reg;
        cnt_next       = cnt_reg;
        emit           = 1'b0;
        emit_last      = 1'b0;
        emit_byte      = b0;
        emit_user      = stream_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next     = ST_RESP;
                    len_next       = 3'd0;
                    idx_next       = 2'd0;
                    cnt_next       = '0;
                    pkt_after_next = 1'b0;
                    resp_next[0]   = RSP_ACK;
                    resp_next[1]   = RSP_ID;
                    resp_next[2]   = RSP_ID;
                    resp_next[3]   = RSP_ID;
                    unique case (q_item.kind)
                        KIND_MOTION:
                        begin
                            pend_x_next = acc_add(pend_x_reg, q_item.dx);
                            pend_y_next = acc_add(pend_y_reg, q_item.dy);
                        end
                        KIND_BUTTON:
                        begin
                            if (q_item.which_button)
                                right_next = q_item.pressed;
                            else
                                left_next = q_item.pressed;
                            chg_next = 1'b1;
                        end
                        KIND_HOST:
                        begin
                            len_next = 3'd1;
                            if (await_reg)
                            begin
                                await_next = 1'b0;
                                if (is_rate_reg)
                                    rate_next = q_item.host_byte;
                                else
                                    res_next = q_item.host_byte[1:0];
                            end
                            else
                            begin
                                unique case (q_item.host_byte)
                                    CMD_SCALE11: scale_next = 1'b0;
                                    CMD_SCALE21: scale_next = 1'b1;
                                    CMD_SET_RES:
                                    begin
                                        is_rate_next = 1'b0;
                                        await_next   = 1'b1;
                                    end
                                    CMD_SET_RATE:
                                    begin
                                        is_rate_next = 1'b1;
                                        await_next   = 1'b1;
                                    end
                                    CMD_STATUS:
                                    begin
                                        len_next     = 3'd4;
                                        resp_next[1] = status;
                                        resp_next[2] = {6'd0, res_reg};
                                        resp_next[3] = rate_reg;
                                    end
                                    CMD_STREAM:    remote_next = 1'b0;
                                    CMD_READ_DATA: pkt_after_next = 1'b1;
                                    CMD_REMOTE:    remote_next = 1'b1;
                                    CMD_GET_ID:    len_next = 3'd2;
                                    CMD_ENABLE:    rep_next = 1'b1;
                                    CMD_DISABLE:   rep_next = 1'b0;
                                    CMD_DEFAULTS, CMD_RESET:
                                    begin
                                        pend_x_next = '0;
                                        pend_y_next = '0;
                                        chg_next    = 1'b0;
                                        rep_next    = 1'b0;
                                        remote_next = 1'b0;
                                        scale_next  = 1'b0;
                                        await_next  = 1'b0;
                                        res_next    = DEF_RES;
                                        rate_next   = DEF_RATE;
                                        if (q_item.host_byte == CMD_RESET)
                                        begin
                                            len_next     = 3'd3;
                                            resp_next[1] = RSP_BAT_OK;
                                        end
                                    end
                                    CMD_RESEND:    resp_next[0] = last_sent_reg;
                                    default:       resp_next[0] = RSP_RESEND;
                                endcase
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_RESP:
            begin
                if (len_reg == 3'd0)
                begin
                    stream_next = 1'b1;
                    state_next  = more ? ST_PKT0 : ST_IDLE;
                end
                else if (fire)
                begin
                    emit      = 1'b1;
                    emit_byte = resp_reg[idx_reg];
                    emit_user = 1'b0;
                    cnt_next  = cnt_reg + 1'b1;
                    if ({1'b0, idx_reg} == len_reg - 3'd1)
                    begin
                        if (pkt_after_reg)
                        begin
                            stream_next = 1'b0;
                            state_next  = ST_PKT0;
                        end
                        else
                        begin
                            stream_next = 1'b1;
                            emit_last   = !more;
                            state_next  = more ? ST_PKT0 : ST_IDLE;
                        end
                    end
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end

            ST_PKT0:
            begin
                if (fire)
                begin
                    emit        = 1'b1;
                    emit_byte   = b0;
                    cnt_next    = cnt_reg + 1'b1;
                    b1_next     = cx[7:0];
                    b2_next     = cy[7:0];
                    pend_x_next = pend_x_reg - acc_t'(cx);
                    pend_y_next = pend_y_reg + acc_t'(cy);
                    chg_next    = 1'b0;
                    state_next  = ST_PKT1;
                end
            end

            ST_PKT1:
            begin
                if (fire)
                begin
                    emit       = 1'b1;
                    emit_byte  = b1_reg;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_PKT2;
                end
            end

            ST_PKT2:
            begin
                if (fire)
                begin
                    emit        = 1'b1;
                    emit_byte   = b2_reg;
                    cnt_next    = cnt_reg + 1'b1;
                    emit_last   = !more;
                    stream_next = 1'b1;
                    state_next  = more ? ST_PKT0 : ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        m_last_next    = m_last_reg;
        last_sent_next = last_sent_reg;
        if (emit)
        begin
            m_valid_next = 1'b1;
            m_data_next  = emit_byte;
            m_user_next  = emit_user;
            m_last_next  = emit_last;
            if (emit_byte != RSP_RESEND)
                last_sent_next = emit_byte;
        end
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_x_reg    <= '0;
            pend_y_reg    <= '0;
            chg_reg       <= 1'b0;
            left_reg      <= 1'b0;
            right_reg     <= 1'b0;
            rep_reg       <= 1'b0;
            remote_reg    <= 1'b0;
            scale_reg     <= 1'b0;
            await_reg     <= 1'b0;
            is_rate_reg   <= 1'b0;
            res_reg       <= DEF_RES;
            rate_reg      <= DEF_RATE;
            last_sent_reg <= '0;
            m_valid_reg   <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_x_reg    <= pend_x_next;
            pend_y_reg    <= pend_y_next;
            chg_reg       <= chg_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            rep_reg       <= rep_next;
            remote_reg    <= remote_next;
            scale_reg     <= scale_next;
            await_reg     <= await_next;
            is_rate_reg   <= is_rate_next;
            res_reg       <= res_next;
            rate_reg      <= rate_next;
            last_sent_reg <= last_sent_next;
            m_valid_reg   <= m_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        resp_reg      <= resp_next;
        len_reg       <= len_next;
        idx_reg       <= idx_next;
        pkt_after_reg <= pkt_after_next;
        stream_reg    <= stream_next;
        b1_reg        <= b1_next;
        b2_reg        <= b2_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    `PMD_ASSERT_ALWAYS(a_cnt_cap, cnt_reg <= CNT_W'(MAX_OUT), "byte count past limit")
    `PMD_ASSERT_IMP(a_pop_idle, q_pop, state_reg == ST_IDLE, "queue popped while busy")
    `PMD_ASSERT_NXT(a_last_idle, emit && emit_last, state_reg == ST_IDLE,
                    "final beat not followed by idle")

endmodule

### rtl/core/ps2_mouse_device.sv
// ----------------------------------------------------------------------------
// PS/2 mouse device
// Top level: front end queue plus command and packet back end.
// ----------------------------------------------------------------------------
// Takes motion, button and host-byte beats on the s_ side and sends the bytes
// a PS/2 mouse would send toward the host on the m_ side, with tuser set on
// stream packet bytes and tlast on the final byte caused by each input beat.
// The front end accepts beats into a two-entry queue as long as it has room,
// so up to two beats are taken while the back end is busy. The back end works
// on one item at a time: it takes an item from the queue and updates state in
// IDLE, then sends each byte from the response or packet states (responses of
// up to four bytes, and three bytes per movement packet); an item that sends no
// response byte still passes through the response state. Bytes go out through a
// one-beat output register, and the back end stalls only while that register is
// full and m_tready is low.
module ps2_mouse_device
    import pmd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // delta_x[10:0], delta_y[21:11], which_button[22],
                                   // pressed[23], host_byte[31:24]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tuser,   // from_stream
    output logic        m_tlast    // last
);

    pmd_item_t q_item;
    logic      q_valid;
    logic      q_pop;

    // front end: classify and queue
    pmd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_item   (q_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop)
    );

    // back end: device state, commands, packets
    pmd_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_item   (q_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// PS/2 mouse device testbench
// Directed command table, then random motion/button/host traffic. Every output
// beat is checked against a behavioral model of the mouse kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import pmd_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // delta_x[10:0], delta_y[21:11], which_button[22],
                            // pressed[23], host_byte[31:24]
    logic [1:0]  s_tuser;   // op[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // out_byte[7:0]
    logic        m_tuser;   // from_stream
    logic        m_tlast;   // last

    ps2_mouse_device u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    localparam int RAND_ITEMS = 410;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic [1:0]  kind;
        logic [10:0] dx;
        logic [10:0] dy;
        logic        btn;
        logic        prs;
        logic [7:0]  hb;
    } mouse_evt_t;

    typedef struct {
        logic [7:0] data;
        logic       strm;
        logic       lst;
    } host_byte_t;

    // directed row: event plus optional typed-in first response byte
    typedef struct {
        mouse_evt_t evt;
        logic       has_exp;
        logic [7:0] exp_first;
    } dir_row_t;

    // mouse state mirror
    int         m_px, m_py;
    bit         m_chg, m_left, m_right, m_rep, m_remote, m_scale, m_await, m_is_rate;
    logic [7:0] m_res, m_rate, m_last_sent;

    host_byte_t expected_bytes[$];
    mouse_evt_t send_q[$];
    int         n_out;
    int         errors;
    int         stream_bytes;
    int         accepted;
    int         idle_cycles;
    bit         stim_done;
    bit         hold_off;

    initial begin
        clk = 1'b0;
    end
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void mouse_defaults();
        m_rep = 0; m_remote = 0; m_scale = 0; m_await = 0;
        m_res = 8'd2; m_rate = 8'd100;
    endfunction

    function automatic void push_byte(logic [7:0] b, bit s);
        host_byte_t h;
        if (n_out >= MAX_OUT)
            return;
        h.data = b; h.strm = s; h.lst = 1'b0;
        expected_bytes.push_back(h);
        n_out++;
        if (b != RSP_RESEND)
            m_last_sent = b;
    endfunction

    function automatic int lim(int v);
        if (v > DELTA_LIMIT) return DELTA_LIMIT;
        if (v < -DELTA_LIMIT) return -DELTA_LIMIT;
        return v;
    endfunction

    function automatic int sat_acc(int v);
        if (v > ACC_MAX) return ACC_MAX;
        if (v < ACC_MIN) return ACC_MIN;
        return v;
    endfunction

    function automatic void movement_packet(bit s);
        int rx, ry, cx, cy;
        logic [7:0] b0;
        rx = m_px; ry = -m_py;
        cx = lim(rx); cy = lim(ry);
        b0 = PKT_B0_BASE | {6'd0, m_right, m_left};
        if (cx < 0) b0 |= 8'h10;
        if (cy < 0) b0 |= 8'h20;
        if (rx != cx) b0 |= 8'h40;
        if (ry != cy) b0 |= 8'h80;
        m_px -= cx; m_py += cy; m_chg = 0;
        push_byte(b0, s);
        push_byte(8'(cx), s);
        push_byte(8'(cy), s);
    endfunction

    function automatic void host_cmd(logic [7:0] v);
        logic [7:0] st;
        if (m_await) begin
            m_await = 0;
            if (m_is_rate) m_rate = v;
            else m_res = {6'd0, v[1:0]};
            push_byte(RSP_ACK, 0);
            return;
        end
        case (v)
            CMD_SCALE11: begin m_scale = 0; push_byte(RSP_ACK, 0); end
            CMD_SCALE21: begin m_scale = 1; push_byte(RSP_ACK, 0); end
            CMD_SET_RES, CMD_SET_RATE:
            begin
                m_is_rate = (v == CMD_SET_RATE); m_await = 1; push_byte(RSP_ACK, 0);
            end
            CMD_STATUS:
            begin
                st = {1'b0, m_remote, m_rep, m_scale, 2'b00, m_right, m_left};
                push_byte(RSP_ACK, 0); push_byte(st, 0);
                push_byte(m_res, 0); push_byte(m_rate, 0);
            end
            CMD_STREAM:    begin m_remote = 0; push_byte(RSP_ACK, 0); end
            CMD_READ_DATA: begin push_byte(RSP_ACK, 0); movement_packet(0); end
            CMD_REMOTE:    begin m_remote = 1; push_byte(RSP_ACK, 0); end
            CMD_GET_ID:    begin push_byte(RSP_ACK, 0); push_byte(RSP_ID, 0); end
            CMD_ENABLE:    begin m_rep = 1; push_byte(RSP_ACK, 0); end
            CMD_DISABLE:   begin m_rep = 0; push_byte(RSP_ACK, 0); end
            CMD_DEFAULTS:
            begin
                push_byte(RSP_ACK, 0); m_px = 0; m_py = 0; m_chg = 0; mouse_defaults();
            end
            CMD_RESEND: push_byte(m_last_sent, 0);
            CMD_RESET:
            begin
                m_px = 0; m_py = 0; m_chg = 0; mouse_defaults();
                push_byte(RSP_ACK, 0); push_byte(RSP_BAT_OK, 0); push_byte(RSP_ID, 0);
            end
            default: push_byte(RSP_RESEND, 0);
        endcase
    endfunction

    // predict all host-bound bytes caused by one accepted event
    function automatic void predict_event(mouse_evt_t e);
        n_out = 0;
        case (e.kind)
            KIND_MOTION:
            begin
                m_px = sat_acc(m_px + int'($signed(e.dx)));
                m_py = sat_acc(m_py + int'($signed(e.dy)));
            end
            KIND_BUTTON:
            begin
                if (e.btn) m_right = e.prs;
                else m_left = e.prs;
                m_chg = 1;
            end
            KIND_HOST: host_cmd(e.hb);
            default: ;
        endcase
        if (m_rep && !m_remote)
            while ((m_px != 0 || m_py != 0 || m_chg) && n_out + 3 <= MAX_OUT)
                movement_packet(1);
        if (n_out > 0)
            expected_bytes[$].lst = 1'b1;
    endfunction

    function automatic mouse_evt_t mk(logic [1:0] k, int x, int y, bit b, bit p,
                                      logic [7:0] h);
        mouse_evt_t e;
        e.kind = k; e.dx = 11'(x); e.dy = 11'(y); e.btn = b; e.prs = p; e.hb = h;
        return e;
    endfunction

    function automatic mouse_evt_t host_evt(logic [7:0] h);
        return mk(KIND_HOST, $urandom, $urandom, 1'($urandom), 1'($urandom), h);
    endfunction

    function automatic mouse_evt_t rand_evt();
        logic [7:0] cmds[14] = '{CMD_SCALE11, CMD_SCALE21, CMD_SET_RES, CMD_STATUS,
            CMD_STREAM, CMD_READ_DATA, CMD_REMOTE, CMD_GET_ID, CMD_SET_RATE,
            CMD_ENABLE, CMD_DISABLE, CMD_DEFAULTS, CMD_RESEND, CMD_RESET};
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            // mostly small motion, sometimes full range to hit saturation
            if ($urandom_range(0, 3) == 0)
                return mk(KIND_MOTION, $urandom, $urandom, 1'($urandom), 1'($urandom),
                          8'($urandom));
            return mk(KIND_MOTION, $urandom_range(0, 80) - 40, $urandom_range(0, 80) - 40,
                      1'($urandom), 1'($urandom), 8'($urandom));
        end
        if (r < 60)
            return mk(KIND_BUTTON, $urandom, $urandom, 1'($urandom), 1'($urandom),
                      8'($urandom));
        if (r < 64)
            return mk(KIND_NONE, $urandom, $urandom, 1'($urandom), 1'($urandom),
                      8'($urandom));
        if (r < 70)
            return host_evt(8'($urandom));  // noise, unknown commands, parameters
        if (r < 80)
            return host_evt(CMD_ENABLE);    // keep stream mode alive
        return host_evt(cmds[$urandom_range(0, 13)]);
    endfunction

    // input driver
    task automatic send_evt(mouse_evt_t e);
        s_tvalid <= 1'b1;
        s_tuser  <= e.kind;
        s_tdata  <= {e.hb, e.prs, e.btn, e.dy, e.dx};
        send_q.push_back(e);
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic sender_gap(bit quiet);
        while (!quiet && $urandom_range(0, 99) < 26) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain();
        while (expected_bytes.size() != 0 || send_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // accept side: predict on input handshake, check on output handshake
    always @(posedge clk)
    begin
        host_byte_t h;
        mouse_evt_t e;
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                e = send_q.pop_front();
                predict_event(e);
                accepted++;
                idle_cycles = 0;
            end
            if (m_tvalid && m_tready) begin
                idle_cycles = 0;
                if (expected_bytes.size() == 0) begin
                    $error("unexpected out beat data=%h", m_tdata);
                    errors++;
                end else begin
                    h = expected_bytes.pop_front();
                    if (m_tdata !== h.data) begin
                        $error("out_byte exp %h got %h", h.data, m_tdata); errors++;
                    end
                    if (m_tuser !== h.strm) begin
                        $error("from_stream exp %0d got %0d", h.strm, m_tuser); errors++;
                    end
                    if (m_tlast !== h.lst) begin
                        $error("last exp %0d got %0d", h.lst, m_tlast); errors++;
                    end
                    if (h.strm) stream_bytes++;
                end
            end
            if (!(s_tvalid && s_tready) && !(m_tvalid && m_tready))
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("ps2_mouse_device regression: fail");
                $finish;
            end
        end
    end

    // receiver: random stalls, a quiet window, and one long hold-off
    initial begin
        int n;
        m_tready = 1'b0;
        @(posedge rst_n);
        n = 0;
        while (1) begin
            @(posedge clk);
            n++;
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
            if (n > 2000 && n < 3000)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= 26);
        end
    end

    initial begin
        dir_row_t   rows[$];
        dir_row_t   r;
        host_byte_t first;
        int         i;
        int         base;

        rst_n = 1'b0; s_tvalid = 1'b0; s_tdata = '0; s_tuser = KIND_NONE;
        errors = 0; stream_bytes = 0; accepted = 0; idle_cycles = 0;
        stim_done = 0; hold_off = 0;
        m_px = 0; m_py = 0; m_chg = 0; m_left = 0; m_right = 0;
        mouse_defaults(); m_is_rate = 0; m_last_sent = 8'h00;

        // directed table: status after reset and error replies are typed in
        rows.push_back('{host_evt(CMD_STATUS), 1, RSP_ACK});
        rows.push_back('{host_evt(CMD_RESEND), 0, 0});
        rows.push_back('{host_evt(8'h00), 1, RSP_RESEND});       // unknown
        rows.push_back('{host_evt(8'hEE), 1, RSP_RESEND});       // echo unsupported
        rows.push_back('{host_evt(CMD_GET_ID), 1, RSP_ACK});
        rows.push_back('{mk(KIND_MOTION, 1023, -1024, 0, 0, 8'hFF), 0, 0});
        rows.push_back('{mk(KIND_MOTION, 1023, -1024, 1, 1, 8'h00), 0, 0});
        rows.push_back('{host_evt(CMD_READ_DATA), 1, RSP_ACK});  // overflow packet
        rows.push_back('{mk(KIND_BUTTON, 0, 0, 0, 1, 0), 0, 0});
        rows.push_back('{mk(KIND_BUTTON, 0, 0, 1, 1, 0), 0, 0});
        rows.push_back('{host_evt(CMD_SCALE21), 1, RSP_ACK});
        rows.push_back('{host_evt(CMD_SET_RES), 1, RSP_ACK});
        rows.push_back('{host_evt(8'hFF), 1, RSP_ACK});          // parameter, not reset
        rows.push_back('{host_evt(CMD_SET_RATE), 1, RSP_ACK});
        rows.push_back('{host_evt(8'h00), 1, RSP_ACK});
        rows.push_back('{host_evt(CMD_STATUS), 0, 0});
        rows.push_back('{host_evt(CMD_ENABLE), 1, RSP_ACK});     // flushes pending
        rows.push_back('{mk(KIND_MOTION, -1024, 1023, 0, 0, 0), 0, 0});
        rows.push_back('{mk(KIND_NONE, 0, 0, 0, 0, 0), 0, 0});
        rows.push_back('{host_evt(CMD_REMOTE), 1, RSP_ACK});
        rows.push_back('{mk(KIND_MOTION, 5, 7, 0, 0, 0), 0, 0});
        rows.push_back('{host_evt(CMD_STREAM), 1, RSP_ACK});
        rows.push_back('{host_evt(CMD_DISABLE), 1, RSP_ACK});
        rows.push_back('{host_evt(CMD_DEFAULTS), 1, RSP_ACK});
        rows.push_back('{host_evt(CMD_RESET), 1, RSP_ACK});

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the table one row at a time so the typed-in byte is the head
        for (i = 0; i < rows.size(); i++) begin
            r = rows[i];
            base = expected_bytes.size();
            send_evt(r.evt);
            s_tvalid <= 1'b0;
            @(posedge clk);
            if (r.has_exp) begin
                first = expected_bytes[base];
                if (first.data !== r.exp_first) begin
                    $error("out_byte exp %h got %h (model)", r.exp_first, first.data);
                    errors++;
                end
            end
            drain();
        end

        // random part; one long receiver hold-off while the sender keeps going
        for (i = 0; i < RAND_ITEMS; i++) begin
            if (i == 100) hold_off = 1;
            sender_gap(i >= 200 && i < 260);
            send_evt(rand_evt());
        end
        s_tvalid <= 1'b0;
        stim_done = 1;
        drain();

        $display("covered %0d accepted events, %0d stream packet bytes", accepted,
                 stream_bytes);
        $display("commands, parameters, saturation, overflow and output stalls exercised");
        if (errors == 0 && expected_bytes.size() == 0)
            $display("ps2_mouse_device regression: pass");
        else
            $display("ps2_mouse_device regression: fail");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/pmd_pkg.sv
rtl/core/pmd_front.sv
rtl/core/pmd_back.sv
rtl/core/ps2_mouse_device.sv
tb/tb.sv
